### hw/rtl/assert_macros.svh
// Assertion macros used by the top level of the reply address selector.
// No dependencies; the macros compile to nothing when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// A property that must hold at every rising edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// When the antecedent holds, the consequent must hold in the same cycle.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// When the antecedent holds, the consequent must hold in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg)
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

### hw/rtl/iras_pkg.sv
// Shared types, constants and helper functions of the reply address selector.
// No dependencies; imported by the cells, the classifier and the top level.
package iras_pkg;

    localparam int MAX_OWN = 8;
    localparam int CNT_W   = $clog2(MAX_OWN + 1);
    localparam int RUN_W   = 3;
    localparam int TDATA_W = 40;

    localparam logic [31:0] LOOPBACK_REPLY = 32'h7F00_0001;

    typedef enum logic [1:0] {
        OP_CLEAR = 2'd0,
        OP_ADD   = 2'd1,
        OP_QUERY = 2'd2
    } opcode_t;

    typedef enum logic [2:0] {
        CLS_MINE = 3'd0,
        CLS_LOOP = 3'd1,
        CLS_LINK = 3'd2,
        CLS_LAN  = 3'd3,
        CLS_WAN  = 3'd4
    } addr_class_t;

    typedef enum logic {
        REG_EXT_ADDR = 1'b0,
        REG_EXT_MASK = 1'b1
    } reg_index_t;

    // One item travelling down the chain, with the partial results gathered so far.
    typedef struct packed {
        logic             valid;
        logic             is_add;
        logic [31:0]      addr;
        logic [3:0]       mask;
        logic [CNT_W-1:0] cnt;
        logic             mine;
        logic [RUN_W-1:0] best_run;
        logic [31:0]      best_val;
    } stage_t;

    // Octet-wise compare; a wildcard octet on either side always matches.
    function automatic logic addr_match(input logic [31:0] a, input logic [3:0] am,
                                        input logic [31:0] b, input logic [3:0] bm);
        logic ok;
        ok = 1'b1;
        for (int i = 0; i < 4; i++) begin
            if (!am[3-i] && !bm[3-i] && (a[31-8*i -: 8] != b[31-8*i -: 8])) begin
                ok = 1'b0;
            end
        end
        return ok;
    endfunction

endpackage

### hw/rtl/iras_cell.sv
// One cell of the own-address chain: holds a single table entry and updates
// the passing item. Depends on iras_pkg.
module iras_cell (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  advance,
    input  logic [iras_pkg::CNT_W-1:0] cell_index,
    input  iras_pkg::stage_t      stage_in,
    output iras_pkg::stage_t      stage_out
);
    import iras_pkg::*;

    logic [31:0] entry_reg;
    stage_t      stage_reg;
    stage_t      stage_next;
    logic [RUN_W-1:0] run;

    // Number of leading octets equal to the query; a wildcard octet ends the run.
    function automatic logic [RUN_W-1:0] lead_run(input logic [31:0] e,
                                                  input logic [31:0] a,
                                                  input logic [3:0] m);
        logic [RUN_W-1:0] r;
        logic             go;
        r  = '0;
        go = 1'b1;
        for (int j = 0; j < 4; j++) begin
            if (go && !m[3-j] && (e[31-8*j -: 8] == a[31-8*j -: 8])) begin
                r = r + RUN_W'(1);
            end else begin
                go = 1'b0;
            end
        end
        return r;
    endfunction

    assign run = lead_run(entry_reg, stage_in.addr, stage_in.mask);

    always_comb begin
        stage_next = stage_in;
        if (stage_in.valid && !stage_in.is_add && (stage_in.cnt > cell_index)) begin
            if (addr_match(entry_reg, 4'b0000, stage_in.addr, stage_in.mask)) begin
                stage_next.mine = 1'b1;
            end
            // Later entries win ties, hence the greater-or-equal.
            if (run >= stage_in.best_run) begin
                stage_next.best_run = run;
                stage_next.best_val = entry_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stage_reg.valid <= 1'b0;
        end else if (advance) begin
            stage_reg <= stage_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && stage_in.valid && stage_in.is_add && (stage_in.cnt == cell_index)) begin
            entry_reg <= stage_in.addr;
        end
    end

    assign stage_out = stage_reg;

endmodule

### hw/rtl/iras_classify.sv
// Final classification and reply selection for an item leaving the chain.
// Depends on iras_pkg; purely combinational, registered by the top level.
module iras_classify (
    input  iras_pkg::stage_t      stage_in,
    input  logic [31:0]           ext_addr,
    input  logic [3:0]            ext_mask,
    output iras_pkg::addr_class_t cls,
    output logic [31:0]           reply_addr,
    output logic [3:0]            reply_mask
);
    import iras_pkg::*;

    localparam logic [31:0] NET_LOOP  = 32'h7F00_0000;
    localparam logic [31:0] NET_LINK  = 32'hA9FE_0000;
    localparam logic [31:0] NET_TEN   = 32'h0A00_0000;
    localparam logic [31:0] NET_C192  = 32'hC0A8_0000;
    localparam logic [7:0]  OCT_172   = 8'd172;
    localparam logic [3:0]  NIB_172   = 4'h1;

    logic        is_mine;
    logic        is_loop;
    logic        is_link;
    logic        is_lan;
    logic        in_172;
    logic [31:0] ext_zeroed;

    function automatic logic [31:0] zero_wild(input logic [31:0] a, input logic [3:0] m);
        logic [31:0] r;
        r = a;
        for (int i = 0; i < 4; i++) begin
            if (m[3-i]) begin
                r[31-8*i -: 8] = 8'h00;
            end
        end
        return r;
    endfunction

    // 172.16/16 to 172.31/16: second octet has upper nibble one, or is a wildcard.
    assign in_172 = (stage_in.mask[3] || (stage_in.addr[31:24] == OCT_172)) &&
                    (stage_in.mask[2] || (stage_in.addr[23:20] == NIB_172));

    assign is_mine = stage_in.mine ||
                     addr_match(ext_addr, ext_mask, stage_in.addr, stage_in.mask);
    assign is_loop = addr_match(NET_LOOP, 4'h7, stage_in.addr, stage_in.mask);
    assign is_link = addr_match(NET_LINK, 4'h3, stage_in.addr, stage_in.mask);
    assign is_lan  = addr_match(NET_TEN, 4'h7, stage_in.addr, stage_in.mask) ||
                     addr_match(NET_C192, 4'h3, stage_in.addr, stage_in.mask) || in_172;

    assign ext_zeroed = zero_wild(ext_addr, ext_mask);

    always_comb begin
        reply_addr = ext_zeroed;
        reply_mask = ext_mask;
        if (is_mine) begin
            cls        = CLS_MINE;
            reply_addr = LOOPBACK_REPLY;
            reply_mask = 4'b0000;
        end else if (is_loop) begin
            cls = CLS_LOOP;
        end else if (is_link) begin
            cls = CLS_LINK;
        end else if (is_lan) begin
            cls = CLS_LAN;
            if (stage_in.best_run != '0) begin
                reply_addr = stage_in.best_val;
                reply_mask = 4'b0000;
            end
        end else begin
            cls = CLS_WAN;
        end
    end

endmodule

### hw/rtl/ipv4_reply_address_selector_top.sv
// Top level of the IPv4 reply address selector: input handling, the chain of
// table cells, the classifier and the output register. Depends on iras_pkg,
// iras_cell, iras_classify and assert_macros.svh.
//
// The block keeps up to MAX_OWN own IPv4 addresses, one in each cell of a
// chain, and answers every query transfer with an address class and a reply
// address. It takes one transfer per cycle whenever the output register is
// free or being emptied. A query passes through the chain, which has one cell
// per table entry and moves each item one cell per cycle unless it is held,
// and from the last cell into the output register. Clear and add
// transfers, and transfers with the unused opcode, give no result. An add
// that arrives while the table is full is dropped. The table count is kept
// at the entry of the chain, so each item carries the count it saw and every
// later item observes the effect of earlier ones in order. The external
// address registers must only be written while the block is idle.
`include "assert_macros.svh"

module ipv4_reply_address_selector_top (
    input  logic                          aclk,
    input  logic                          aresetn,

    // Input stream.
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [iras_pkg::TDATA_W-1:0]  s_tdata,   // [31:0] address, [35:32] wild_mask
    input  logic [1:0]                    s_tuser,   // [1:0] opcode

    // Result stream.
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [iras_pkg::TDATA_W-1:0]  m_tdata,   // [31:0] reply_address,
                                                     // [35:32] reply_wild_mask
    output logic [2:0]                    m_tuser,   // [2:0] address_class

    // Configuration write port.
    input  logic                          cfg_wr_en,
    input  logic                          cfg_wr_index,
    input  logic [31:0]                   cfg_wr_data
);
    import iras_pkg::*;

    // Configuration registers.
    logic [31:0] ext_addr_reg;
    logic [3:0]  ext_mask_reg;

    // Number of valid table entries.
    logic [CNT_W-1:0] own_count_reg;
    logic [CNT_W-1:0] own_count_next;

    // Output register.
    logic             m_valid_reg;
    addr_class_t      cls_reg;
    logic [31:0]      reply_addr_reg;
    logic [3:0]       reply_mask_reg;

    // The whole chain moves together; it only holds when a result waits unread.
    logic             advance;
    logic             accept;
    opcode_t          opcode;
    logic             table_full;
    stage_t           chain [0:MAX_OWN];

    addr_class_t      cls;
    logic [31:0]      reply_addr;
    logic [3:0]       reply_mask;

    assign advance    = !m_valid_reg || m_tready;
    assign s_tready   = advance;
    assign accept     = s_tvalid && s_tready;
    assign opcode     = opcode_t'(s_tuser);
    assign table_full = (own_count_reg == CNT_W'(MAX_OWN));

    // Build the item that enters the first cell. An add carries its target
    // index in the count field; a query carries the number of valid entries.
    always_comb begin
        chain[0]          = '0;
        chain[0].addr     = s_tdata[31:0];
        chain[0].mask     = s_tdata[35:32];
        chain[0].cnt      = own_count_reg;
        own_count_next    = own_count_reg;
        case (opcode)
            OP_CLEAR: begin
                own_count_next = '0;
            end
            OP_ADD: begin
                chain[0].is_add = 1'b1;
                if (!table_full) begin
                    chain[0].valid = accept;
                    own_count_next = own_count_reg + CNT_W'(1);
                end
            end
            OP_QUERY: begin
                chain[0].valid = accept;
            end
            default: begin
                own_count_next = own_count_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            own_count_reg <= '0;
        end else if (accept) begin
            own_count_reg <= own_count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ext_addr_reg <= '0;
            ext_mask_reg <= 4'hF;
        end else if (cfg_wr_en) begin
            case (reg_index_t'(cfg_wr_index))
                REG_EXT_ADDR: ext_addr_reg <= cfg_wr_data;
                REG_EXT_MASK: ext_mask_reg <= cfg_wr_data[3:0];
                default:      ext_addr_reg <= ext_addr_reg;
            endcase
        end
    end

    // One cell per table entry.
    for (genvar k = 0; k < MAX_OWN; k++) begin : g_cell
        iras_cell u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .advance    (advance),
            .cell_index (CNT_W'(k)),
            .stage_in   (chain[k]),
            .stage_out  (chain[k+1])
        );
    end

    iras_classify u_classify (
        .stage_in   (chain[MAX_OWN]),
        .ext_addr   (ext_addr_reg),
        .ext_mask   (ext_mask_reg),
        .cls        (cls),
        .reply_addr (reply_addr),
        .reply_mask (reply_mask)
    );

    // Only queries leave a result; adds end their journey here.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= chain[MAX_OWN].valid && !chain[MAX_OWN].is_add;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            cls_reg        <= cls;
            reply_addr_reg <= reply_addr;
            reply_mask_reg <= reply_mask;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(TDATA_W - 36){1'b0}}, reply_mask_reg, reply_addr_reg};
    assign m_tuser  = cls_reg;

    // The table never holds more entries than there are cells.
    `ASSERT_ALWAYS(a_count_bound, aclk, aresetn, own_count_reg <= CNT_W'(MAX_OWN), "count overflow")

    // A clear transfer empties the table at once.
    `ASSERT_NEXT(a_clear_empties, aclk, aresetn, accept && (opcode == OP_CLEAR), own_count_reg == '0, "clear did not empty")

    // A result of class mine always answers with the loopback address.
    `ASSERT_IMPL(a_mine_reply, aclk, aresetn, m_valid_reg && (cls_reg == CLS_MINE), (reply_addr_reg == LOOPBACK_REPLY) && (reply_mask_reg == 4'b0000), "bad mine reply")

    // The chain holds whenever a result waits unread.
    `ASSERT_NEXT(a_hold_chain, aclk, aresetn, m_valid_reg && !m_tready, $stable(chain[MAX_OWN]), "chain moved under stall")

endmodule

### bench/ipv4_reply_address_selector_top_tb.sv
// Self-checking testbench for ipv4_reply_address_selector_top: drives the input stream,
// predicts every query reply from its own model of the address table and the external
// address, and checks each result transfer. Depends on iras_pkg and the RTL top level.
module ipv4_reply_address_selector_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import iras_pkg::*;

    localparam int CLK_HALF = 4;
    localparam int RESET_CYCLES = 5;
    // The chain has one cell per table entry plus an output register; the settle wait
    // is ample for a clear or an add still on its way through.
    localparam int SETTLE_CYCLES = 2 * (MAX_OWN + 1);
    localparam int HOLD_CYCLES = 400;
    localparam int REPORT_LIMIT = 100;

    // The fourth opcode has no meaning; the block must swallow it without a result.
    localparam logic [1:0] OP_RESERVED = 2'd3;

    // Fixed networks of the classifier, with the wildcard masks that cover them.
    localparam logic [31:0] NET_LOOPBACK = 32'h7F00_0000;
    localparam logic [31:0] NET_LINK_LOCAL = 32'hA9FE_0000;
    localparam logic [31:0] NET_TEN = 32'h0A00_0000;
    localparam logic [31:0] NET_192_168 = 32'hC0A8_0000;
    localparam logic [3:0] WILD_LAST3 = 4'b0111;
    localparam logic [3:0] WILD_LAST2 = 4'b0011;

    typedef struct packed {
        addr_class_t cls;
        logic [31:0] addr;
        logic [3:0]  mask;
    } reply_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;

    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [TDATA_W-1:0] s_tdata = '0;
    logic [1:0] s_tuser = OP_CLEAR;

    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [TDATA_W-1:0] m_tdata;
    logic [2:0] m_tuser;

    logic cfg_wr_en = 1'b0;
    reg_index_t cfg_wr_index = REG_EXT_ADDR;
    logic [31:0] cfg_wr_data = '0;

    // The testbench's own copy of the block state, in reset condition.
    logic [31:0] own_addrs [MAX_OWN];
    int own_count = 0;
    logic [31:0] ext_addr = 32'h0;
    logic [3:0] ext_mask = 4'hF;

    // Replies still owed by the block, oldest first.
    reply_t pending_replies [$];

    int failures = 0;
    int items_accepted = 0;
    int effective_items = 0;
    int results_checked = 0;
    int class_seen [5] = '{default: 0};

    // Sender idling: bursts of random length separated by random gaps.
    bit idle_enabled = 1'b1;
    int burst_left = 0;

    // Receiver stall pattern and the long hold-off requested by the pressure test.
    int hold_requests = 0;
    int hold_served = 0;
    int hold_left = 0;
    int ready_mode = 0;
    int mode_left = 0;

    ipv4_reply_address_selector_top i_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data)
    );

    always #CLK_HALF aclk = ~aclk;

    // Widens a per-octet wildcard mask to a bit mask over the whole address.
    function automatic logic [31:0] octet_spread(input logic [3:0] m);
        return {{8{m[3]}}, {8{m[2]}}, {8{m[1]}}, {8{m[0]}}};
    endfunction

    // Two addresses agree when every octet that is concrete on both sides is equal.
    function automatic logic octets_agree(input logic [31:0] a, input logic [3:0] am,
                                          input logic [31:0] b, input logic [3:0] bm);
        return ((a ^ b) & ~octet_spread(am | bm)) == 32'h0;
    endfunction

    function automatic addr_class_t classify_peer(input logic [31:0] peer,
                                                  input logic [3:0] pm);
        for (int i = 0; i < own_count; i++) begin
            if (octets_agree(own_addrs[i], 4'h0, peer, pm)) begin
                return CLS_MINE;
            end
        end
        if (octets_agree(ext_addr, ext_mask, peer, pm)) begin
            return CLS_MINE;
        end
        if (octets_agree(NET_LOOPBACK, WILD_LAST3, peer, pm)) begin
            return CLS_LOOP;
        end
        if (octets_agree(NET_LINK_LOCAL, WILD_LAST2, peer, pm)) begin
            return CLS_LINK;
        end
        if (octets_agree(NET_TEN, WILD_LAST3, peer, pm) ||
            octets_agree(NET_192_168, WILD_LAST2, peer, pm)) begin
            return CLS_LAN;
        end
        // Only 172.16 to 172.31 are private; 172.241 is an ordinary public net.
        for (int s = 16; s <= 31; s++) begin
            if (octets_agree({8'd172, 8'(s), 16'h0}, WILD_LAST2, peer, pm)) begin
                return CLS_LAN;
            end
        end
        return CLS_WAN;
    endfunction

    function automatic reply_t select_reply(input logic [31:0] peer, input logic [3:0] pm);
        reply_t r;
        int best;
        int best_idx;
        int run;
        r.cls = classify_peer(peer, pm);
        r.addr = ext_addr & ~octet_spread(ext_mask);
        r.mask = ext_mask;
        if (r.cls == CLS_MINE) begin
            r.addr = LOOPBACK_REPLY;
            r.mask = 4'h0;
        end else if (r.cls == CLS_LAN) begin
            // Longest run of leading equal octets; a wildcard octet in the query ends
            // the run, and the later entry wins a tie.
            best = 0;
            best_idx = 0;
            for (int i = 0; i < own_count; i++) begin
                run = 0;
                while (run < 4 && !pm[3-run] &&
                       own_addrs[i][31-8*run -: 8] == peer[31-8*run -: 8]) begin
                    run++;
                end
                if (run >= best) begin
                    best = run;
                    best_idx = i;
                end
            end
            if (best != 0) begin
                r.addr = own_addrs[best_idx];
                r.mask = 4'h0;
            end
        end
        return r;
    endfunction

    // Random address that keeps the first k octets of src.
    function automatic logic [31:0] keep_prefix(input logic [31:0] src, input int k);
        logic [31:0] r;
        r = $urandom;
        for (int j = 0; j < k; j++) begin
            r[31-8*j -: 8] = src[31-8*j -: 8];
        end
        return r;
    endfunction

    function automatic void flag_mismatch(input string field, input logic [31:0] want,
                                          input logic [31:0] got);
        failures++;
        if (failures <= REPORT_LIMIT) begin
            $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
        end
    endfunction

    // Offers one transfer, waits for the handshake and then updates the model. Between
    // transfers the sender may drop tvalid for a gap, depending on where its burst is.
    task automatic send_item(input logic [1:0] op, input logic [31:0] addr,
                             input logic [3:0] wmask);
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= {{(TDATA_W-36){1'b0}}, wmask, addr};
        @(posedge aclk);
        while (!s_tready) begin
            @(posedge aclk);
        end
        items_accepted++;
        case (op)
            OP_CLEAR: begin
                own_count = 0;
                effective_items++;
            end
            OP_ADD: begin
                // A full table drops the add.
                if (own_count < MAX_OWN) begin
                    own_addrs[own_count] = addr;
                    own_count++;
                    effective_items++;
                end
            end
            OP_QUERY: begin
                pending_replies.insert(pending_replies.size(), select_reply(addr, wmask));
                effective_items++;
            end
            default: begin
            end
        endcase
        if (idle_enabled) begin
            if (burst_left == 0) begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge aclk);
                burst_left = $urandom_range(1, 24);
            end else begin
                burst_left--;
            end
        end
    endtask

    // Stops offering, waits for every owed reply and lets any clear or add still in
    // the chain run out, so that the block is idle afterwards.
    task automatic drain_pipeline();
        s_tvalid <= 1'b0;
        while (pending_replies.size() != 0) begin
            @(posedge aclk);
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Both external registers are written, back to back, only once the block is idle.
    task automatic reconfigure_external(input logic [31:0] addr, input logic [3:0] wmask);
        drain_pipeline();
        cfg_wr_en <= 1'b1;
        cfg_wr_index <= REG_EXT_ADDR;
        cfg_wr_data <= addr;
        @(posedge aclk);
        cfg_wr_index <= REG_EXT_MASK;
        cfg_wr_data <= {28'h0, wmask};
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        ext_addr = addr;
        ext_mask = wmask;
    endtask

    // Out of reset the external address is all wildcards, so every query is mine,
    // even one that would otherwise be loopback.
    task automatic test_unconfigured_external();
        send_item(OP_QUERY, 32'h0808_0808, 4'h0);
        send_item(OP_QUERY, 32'hFFFF_FFFF, 4'hF);
        send_item(OP_RESERVED, 32'hFFFF_FFFF, 4'hF);
        send_item(OP_QUERY, 32'h7F00_0001, 4'h0);
    endtask

    // One query per class and per edge of the fixed networks, with an empty table.
    task automatic test_address_classes();
        reconfigure_external(32'hCB00_7107, 4'h0);
        send_item(OP_QUERY, 32'h7F05_0607, 4'h0);
        send_item(OP_QUERY, 32'hA9FE_0102, 4'h0);
        send_item(OP_QUERY, 32'hA9FD_0102, 4'h0);
        // Private with nothing in the table: the reply falls back to the external address.
        send_item(OP_QUERY, 32'hAC10_0001, 4'h0);
        send_item(OP_QUERY, 32'hAC1F_FFFF, 4'h0);
        // 172.241 and 172.32 lie outside the private range.
        send_item(OP_QUERY, 32'hACF1_0001, 4'h0);
        send_item(OP_QUERY, 32'hAC20_0001, 4'h0);
        send_item(OP_QUERY, 32'hCB00_7107, 4'h0);
        // A wildcard first octet in the query matches the loopback network.
        send_item(OP_QUERY, 32'h00FE_0101, 4'b1000);
        send_item(OP_QUERY, 32'h0000_0000, 4'h0);
    endtask

    // Fills the table past its capacity and exercises the longest prefix choice.
    task automatic test_own_table();
        send_item(OP_CLEAR, 32'h0, 4'h0);
        send_item(OP_ADD, 32'h0A01_0203, 4'h0);
        send_item(OP_ADD, 32'h0A01_0909, 4'h0);
        send_item(OP_ADD, 32'hC0A8_0701, 4'hF);
        send_item(OP_ADD, 32'h0A01_02C8, 4'h0);
        send_item(OP_ADD, 32'hAC14_0005, 4'h0);
        send_item(OP_ADD, 32'h0A09_0909, 4'h0);
        send_item(OP_ADD, 32'hC0A8_0709, 4'h0);
        send_item(OP_ADD, 32'h0AC8_0001, 4'h0);
        // The table is full, so this entry is dropped and stays unknown.
        send_item(OP_ADD, 32'h0A4D_0001, 4'h0);
        send_item(OP_QUERY, 32'h0A01_0203, 4'h0);
        send_item(OP_QUERY, 32'h0A01_0204, 4'h0);
        send_item(OP_QUERY, 32'h0A4D_0001, 4'h0);
        // A wildcard third octet cuts the prefix run at two octets.
        send_item(OP_QUERY, 32'h0A01_0705, 4'b0010);
        send_item(OP_CLEAR, 32'hFFFF_FFFF, 4'hF);
        send_item(OP_QUERY, 32'h0A01_0203, 4'h0);
    endtask

    // The receiver holds off for a long stretch while the sender keeps offering back to
    // back, so the chain fills and the input stalls; then the sender waits for it all.
    task automatic test_receiver_hold();
        drain_pipeline();
        send_item(OP_ADD, 32'hC0A8_0A01, 4'h0);
        send_item(OP_ADD, 32'h0A0A_0A0A, 4'h0);
        idle_enabled = 1'b0;
        hold_requests++;
        repeat (48) begin
            send_item(OP_QUERY, ($urandom_range(1) != 0) ? {16'hC0A8, 16'($urandom)}
                                                         : $urandom, 4'($urandom));
        end
        drain_pipeline();
        idle_enabled = 1'b1;
    endtask

    // One table episode: usually a clear, a run of adds around a common network (at
    // times more than fit), then queries near the entries, the fixed networks and the
    // external address, with the odd stray transfer in between.
    task automatic random_episode();
        logic [31:0] seed;
        logic [31:0] peer;
        logic [3:0]  pm;
        int          pick;
        case ($urandom_range(4))
            0: seed = {8'd10, 24'($urandom)};
            1: seed = {16'hC0A8, 16'($urandom)};
            2: seed = {8'd172, 8'($urandom_range(16, 31)), 16'($urandom)};
            3: seed = {8'd172, 8'($urandom_range(12, 35)), 16'($urandom)};
            default: seed = $urandom;
        endcase
        if ($urandom_range(99) < 85) begin
            send_item(OP_CLEAR, $urandom, 4'($urandom));
        end
        repeat ($urandom_range(10)) begin
            send_item(OP_ADD, keep_prefix(seed, $urandom_range(1, 3)), 4'($urandom));
        end
        repeat ($urandom_range(8, 30)) begin
            pm = ($urandom_range(99) < 70) ? 4'h0 : 4'($urandom);
            pick = $urandom_range(99);
            if (pick < 30 && own_count > 0) begin
                peer = keep_prefix(own_addrs[$urandom_range(own_count - 1)],
                                   $urandom_range(4));
            end else if (pick < 50) begin
                peer = keep_prefix(seed, $urandom_range(4));
            end else if (pick < 65) begin
                case ($urandom_range(4))
                    0: peer = {8'd127, 24'($urandom)};
                    1: peer = {8'd169, 8'($urandom_range(252, 255)), 16'($urandom)};
                    2: peer = {8'd172, 8'($urandom_range(14, 33)), 16'($urandom)};
                    3: peer = {16'hACF1, 16'($urandom)};
                    default: peer = {8'($urandom_range(9, 11)), 24'($urandom)};
                endcase
            end else if (pick < 75) begin
                peer = keep_prefix(ext_addr, $urandom_range(2, 4));
            end else begin
                peer = $urandom;
            end
            if ($urandom_range(99) < 5) begin
                case ($urandom_range(2))
                    0: send_item(OP_RESERVED, $urandom, 4'($urandom));
                    1: send_item(OP_ADD, $urandom, 4'($urandom));
                    default: send_item(OP_CLEAR, $urandom, 4'($urandom));
                endcase
            end
            send_item(OP_QUERY, peer, pm);
        end
    endtask

    // Random traffic under six external address settings, the extremes among them.
    task automatic test_random_traffic();
        int target;
        for (int p = 0; p < 6; p++) begin
            case (p)
                0: reconfigure_external(32'h0000_0000, 4'h0);
                1: reconfigure_external(32'hFFFF_FFFF, 4'h0);
                2: reconfigure_external($urandom, 4'b0001);
                3: reconfigure_external($urandom, 4'($urandom_range(14)));
                4: reconfigure_external($urandom, 4'hF);
                default: reconfigure_external({16'hAC14, 16'($urandom)}, 4'h0);
            endcase
            // With an all-wildcard external address every query is mine: keep it short.
            target = effective_items + ((p == 4) ? 100 : 300);
            while (effective_items < target) begin
                idle_enabled = ($urandom_range(3) != 0);
                random_episode();
            end
        end
        idle_enabled = 1'b1;
    endtask

    // The receiver walks through stall patterns of its own and serves the hold-off
    // requests of the pressure test, counting the cycles itself.
    always @(posedge aclk) begin
        if (hold_left > 0) begin
            m_tready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_served != hold_requests) begin
            hold_served <= hold_requests;
            hold_left <= HOLD_CYCLES;
            m_tready <= 1'b0;
        end else begin
            if (mode_left == 0) begin
                ready_mode <= $urandom_range(3);
                mode_left <= $urandom_range(40, 300);
            end else begin
                mode_left <= mode_left - 1;
            end
            case (ready_mode)
                0: m_tready <= 1'b1;
                1: m_tready <= ($urandom_range(3) != 0);
                2: m_tready <= ($urandom_range(1) != 0);
                default: m_tready <= ($urandom_range(7) == 0);
            endcase
        end
    end

    // Every result transfer is compared with the oldest owed reply.
    always @(posedge aclk) begin : result_check
        reply_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_replies.size() == 0) begin
                failures++;
                $error("unexpected result: class %0d, address 0x%0h, mask 0x%0h",
                       m_tuser, m_tdata[31:0], m_tdata[35:32]);
            end else begin
                want = pending_replies.pop_front();
                results_checked++;
                class_seen[want.cls]++;
                if (m_tuser !== want.cls) begin
                    flag_mismatch("address_class", 32'(want.cls), 32'(m_tuser));
                end
                if (m_tdata[31:0] !== want.addr) begin
                    flag_mismatch("reply_address", want.addr, m_tdata[31:0]);
                end
                if (m_tdata[35:32] !== want.mask) begin
                    flag_mismatch("reply_wild_mask", 32'(want.mask), 32'(m_tdata[35:32]));
                end
            end
        end
    end

    initial begin
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_unconfigured_external();
        test_address_classes();
        test_own_table();
        test_receiver_hold();
        test_random_traffic();
        drain_pipeline();

        $display("Checked %0d replies from %0d accepted transfers over six external settings.",
                 results_checked, items_accepted);
        $display("Replies by class: mine %0d, loopback %0d, link-local %0d, private %0d, wan %0d.",
                 class_seen[CLS_MINE], class_seen[CLS_LOOP], class_seen[CLS_LINK],
                 class_seen[CLS_LAN], class_seen[CLS_WAN]);
        if (failures == 0) begin
            $display("ipv4_reply_address_selector_top: match");
        end else begin
            $display("ipv4_reply_address_selector_top: mismatch");
        end
        $finish;
    end

    // Several times the slowest correct run; reaching it means the block has hung.
    initial begin
        #4ms;
        $display("ipv4_reply_address_selector_top: mismatch");
        $finish;
    end

endmodule
